>>> hw/rtl/e2c_pkg.sv
// ----------------------------------------------------------------------------
// e2c_pkg
// Shared widths, constants and the month table for the epoch to calendar
// conversion pipeline.
// ----------------------------------------------------------------------------
package e2c_pkg;

    localparam int unsigned SECS_W  = 32;
    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;

    localparam int unsigned DAYS_W  = 16;   // day count, below 49711
    localparam int unsigned TOD_W   = 17;   // seconds of day, below 86400
    localparam int unsigned DOY_W   = 9;    // day of year, below 366

    // seconds / 86400 = (seconds >> 7) / 675
    localparam logic [9:0]  DAY_FACTOR   = 10'd675;
    localparam logic [22:0] DAY_RECIP    = 23'd6362914;   // floor(2^32 / 675)

    // seconds of day / 3600 = (tod >> 4) / 225
    localparam logic [13:0] HOUR_RECIP   = 14'd9321;      // ceil(2^21 / 225)
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;

    // remainder / 60 = (rem >> 2) / 15
    localparam logic [10:0] MIN_RECIP    = 11'd1093;      // ceil(2^14 / 15)
    localparam logic [5:0]  SECS_PER_MIN = 6'd60;

    // Four-year cycles counted from 1968-01-01 (a leap year)
    localparam logic [10:0] CYCLE_DAYS   = 11'd1461;
    localparam logic [15:0] CYCLE_RECIP  = 16'd45934;     // ceil(2^26 / 1461)
    localparam logic [15:0] EPOCH_OFFSET = 16'd731;       // 1968 + 1969
    localparam logic [15:0] SKIP_DAY     = 16'd47541;     // 2100-03-01
    localparam logic [YEAR_W-1:0] ORIGIN_YEAR = 12'd1968;

    localparam logic [10:0] YEAR1_START  = 11'd366;
    localparam logic [10:0] YEAR2_START  = 11'd731;
    localparam logic [10:0] YEAR3_START  = 11'd1096;

    // Days in the year before the given month (0 = January)
    function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] idx,
                                                     input logic               leap);
        logic [DOY_W-1:0] base;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (idx >= 4'd2))
        begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

>>> hw/rtl/epoch_to_calendar_top.sv
// ----------------------------------------------------------------------------
// epoch_to_calendar_top
// Converts a 32-bit seconds count since 1970-01-01 00:00:00 into a Gregorian
// date and time of day, fully pipelined.
// ----------------------------------------------------------------------------
// Every 32-bit input is legal and yields one result transfer, 1970-01-01
// 00:00:00 up to 2106-02-07 06:28:15. The block takes one transfer per clock
// while no result waits on a stalled output, and returns the results in order
// through nine register stages (three for the day split, six for the calendar).
// A stalled output holds the whole pipeline, so the
// input is stalled for as long as a finished result waits on a stalled
// output; nothing is dropped or repeated. Full leap-year rules apply: the
// year 2000 is a leap year and 2100 is not.
// ----------------------------------------------------------------------------
module epoch_to_calendar_top
    import e2c_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    // input channel
    input  logic               epoch_valid,
    output logic               epoch_stall,
    input  logic [SECS_W-1:0]  epoch_seconds,

    // result channel
    output logic               date_valid,
    input  logic               date_stall,
    output logic [YEAR_W-1:0]  year,
    output logic [MONTH_W-1:0] month,
    output logic [DAY_W-1:0]   day_of_month,
    output logic [HOUR_W-1:0]  hour,
    output logic [MIN_W-1:0]   minute,
    output logic [SEC_W-1:0]   second
);

    localparam int unsigned DEPTH = 9;

    // Pipeline advance: everything moves unless a result is held at the
    // output by a stall.
    logic             advance;
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;

    assign advance     = !(valid_reg[DEPTH-1] && date_stall);
    assign epoch_stall = !advance;
    assign date_valid  = valid_reg[DEPTH-1];

    // Valid bits travel alongside the data stages.
    assign valid_next = {valid_reg[DEPTH-2:0], epoch_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    // Day split: days since epoch and seconds of day.
    logic [DAYS_W-1:0] days;
    logic [TOD_W-1:0]  tod;

    e2c_day_div u_day_div
    (
        .clk  (clk),
        .en   (advance),
        .secs (epoch_seconds),
        .days (days),
        .tod  (tod)
    );

    // Calendar: year, month, day and clock fields; last stage is the
    // output register.
    e2c_calendar u_calendar
    (
        .clk          (clk),
        .en           (advance),
        .days         (days),
        .tod          (tod),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month),
        .hour         (hour),
        .minute       (minute),
        .second       (second)
    );

endmodule

>>> hw/rtl/e2c_day_div.sv
// ----------------------------------------------------------------------------
// e2c_day_div
// Three-stage split of an epoch seconds count into whole days and seconds
// of day, by reciprocal multiplication with one correction step.
// ----------------------------------------------------------------------------
module e2c_day_div
    import e2c_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [SECS_W-1:0] secs,
    output logic [DAYS_W-1:0] days,
    output logic [TOD_W-1:0]  tod
);

    // stage 1: quotient estimate, low by at most one
    logic [47:0] est_prod;
    logic [15:0] qest_reg;
    logic [24:0] hi1_reg;
    logic [6:0]  lo1_reg;

    assign est_prod = 48'(secs[31:7]) * 48'(DAY_RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qest_reg <= est_prod[47:32];
            hi1_reg  <= secs[31:7];
            lo1_reg  <= secs[6:0];
        end
    end

    // stage 2: remainder of the estimate, below 2 * 675
    logic [25:0] back_prod;
    logic [24:0] diff2;
    logic [15:0] q2_reg;
    logic [10:0] r2_reg;
    logic [6:0]  lo2_reg;

    assign back_prod = 26'(qest_reg) * 26'(DAY_FACTOR);
    assign diff2     = hi1_reg - back_prod[24:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q2_reg  <= qest_reg;
            r2_reg  <= diff2[10:0];
            lo2_reg <= lo1_reg;
        end
    end

    // stage 3: correction
    logic [DAYS_W-1:0] days_next;
    logic [10:0]       r3;
    logic [DAYS_W-1:0] days_reg;
    logic [TOD_W-1:0]  tod_reg;

    always_comb
    begin
        if (r2_reg >= 11'(DAY_FACTOR))
        begin
            days_next = q2_reg + 16'd1;
            r3        = r2_reg - 11'(DAY_FACTOR);
        end
        else
        begin
            days_next = q2_reg;
            r3        = r2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            days_reg <= days_next;
            tod_reg  <= {r3[9:0], lo2_reg};
        end
    end

    assign days = days_reg;
    assign tod  = tod_reg;

endmodule

>>> hw/rtl/e2c_calendar.sv
// ----------------------------------------------------------------------------
// e2c_calendar
// Six-stage conversion of a day count and seconds of day into year, month,
// day of month, hour, minute and second.
// ----------------------------------------------------------------------------
module e2c_calendar
    import e2c_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [DAYS_W-1:0]  days,
    input  logic [TOD_W-1:0]   tod,
    output logic [YEAR_W-1:0]  year,
    output logic [MONTH_W-1:0] month,
    output logic [DAY_W-1:0]   day_of_month,
    output logic [HOUR_W-1:0]  hour,
    output logic [MIN_W-1:0]   minute,
    output logic [SEC_W-1:0]   second
);

    // c1: rebase to 1968, skip the missing 29 Feb 2100; hour
    logic [DAYS_W-1:0] dp_next;
    logic [26:0]       hour_prod;
    logic [DAYS_W-1:0] dp1_reg;
    logic [TOD_W-1:0]  tod1_reg;
    logic [HOUR_W-1:0] hour1_reg;

    assign dp_next   = days + EPOCH_OFFSET + 16'(days >= SKIP_DAY);
    assign hour_prod = 27'(tod[16:4]) * 27'(HOUR_RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dp1_reg   <= dp_next;
            tod1_reg  <= tod;
            hour1_reg <= hour_prod[25:21];
        end
    end

    // c2: four-year cycle count; seconds within the hour
    logic [31:0]       cyc_prod;
    logic [16:0]       hour_secs;
    logic [16:0]       remh_full;
    logic [5:0]        q4_2_reg;
    logic [DAYS_W-1:0] dp2_reg;
    logic [HOUR_W-1:0] hour2_reg;
    logic [11:0]       remh2_reg;

    assign cyc_prod  = 32'(dp1_reg) * 32'(CYCLE_RECIP);
    assign hour_secs = 17'(hour1_reg) * 17'(SECS_PER_HOUR);
    assign remh_full = tod1_reg - hour_secs;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q4_2_reg  <= cyc_prod[31:26];
            dp2_reg   <= dp1_reg;
            hour2_reg <= hour1_reg;
            remh2_reg <= remh_full[11:0];
        end
    end

    // c3: day within the cycle; minute
    logic [16:0]       cyc_days;
    logic [DAYS_W-1:0] r4_full;
    logic [20:0]       min_prod;
    logic [10:0]       r4_3_reg;
    logic [5:0]        q4_3_reg;
    logic [HOUR_W-1:0] hour3_reg;
    logic [11:0]       remh3_reg;
    logic [MIN_W-1:0]  min3_reg;

    assign cyc_days = 17'(q4_2_reg) * 17'(CYCLE_DAYS);
    assign r4_full  = dp2_reg - cyc_days[15:0];
    assign min_prod = 21'(remh2_reg[11:2]) * 21'(MIN_RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r4_3_reg  <= r4_full[10:0];
            q4_3_reg  <= q4_2_reg;
            hour3_reg <= hour2_reg;
            remh3_reg <= remh2_reg;
            min3_reg  <= min_prod[19:14];
        end
    end

    // c4: year within the cycle, day of year; second
    logic [1:0]        yc;
    logic [10:0]       ystart;
    logic [10:0]       doy_full;
    logic [YEAR_W-1:0] year_next;
    logic [11:0]       min_secs;
    logic [11:0]       sec_full;
    logic [YEAR_W-1:0] year4_reg;
    logic [DOY_W-1:0]  doy4_reg;
    logic              leap4_reg;
    logic [HOUR_W-1:0] hour4_reg;
    logic [MIN_W-1:0]  min4_reg;
    logic [SEC_W-1:0]  sec4_reg;

    always_comb
    begin
        if (r4_3_reg < YEAR1_START)
        begin
            yc     = 2'd0;
            ystart = 11'd0;
        end
        else if (r4_3_reg < YEAR2_START)
        begin
            yc     = 2'd1;
            ystart = YEAR1_START;
        end
        else if (r4_3_reg < YEAR3_START)
        begin
            yc     = 2'd2;
            ystart = YEAR2_START;
        end
        else
        begin
            yc     = 2'd3;
            ystart = YEAR3_START;
        end
    end

    assign doy_full  = r4_3_reg - ystart;
    assign year_next = ORIGIN_YEAR + {4'd0, q4_3_reg, 2'b00} + 12'(yc);
    assign min_secs  = 12'(min3_reg) * 12'(SECS_PER_MIN);
    assign sec_full  = remh3_reg - min_secs;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            year4_reg <= year_next;
            doy4_reg  <= doy_full[8:0];
            leap4_reg <= (yc == 2'd0);
            hour4_reg <= hour3_reg;
            min4_reg  <= min3_reg;
            sec4_reg  <= sec_full[5:0];
        end
    end

    // c5: month by parallel compare against month starts
    logic [MONTH_W-1:0] month_next;
    logic [YEAR_W-1:0]  year5_reg;
    logic [MONTH_W-1:0] month5_reg;
    logic [DOY_W-1:0]   doy5_reg;
    logic               leap5_reg;
    logic [HOUR_W-1:0]  hour5_reg;
    logic [MIN_W-1:0]   min5_reg;
    logic [SEC_W-1:0]   sec5_reg;

    always_comb
    begin
        month_next = 4'd1;
        for (int k = 1; k < 12; k++)
        begin
            if (doy4_reg >= month_start(MONTH_W'(k), leap4_reg))
            begin
                month_next = month_next + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            year5_reg  <= year4_reg;
            month5_reg <= month_next;
            doy5_reg   <= doy4_reg;
            leap5_reg  <= leap4_reg;
            hour5_reg  <= hour4_reg;
            min5_reg   <= min4_reg;
            sec5_reg   <= sec4_reg;
        end
    end

    // c6: day of month, output register
    logic [DOY_W-1:0]   dom_full;
    logic [YEAR_W-1:0]  year_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [DAY_W-1:0]   dom_reg;
    logic [HOUR_W-1:0]  hour_reg;
    logic [MIN_W-1:0]   min_reg;
    logic [SEC_W-1:0]   sec_reg;

    assign dom_full = doy5_reg - month_start(month5_reg - 4'd1, leap5_reg) + 9'd1;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            year_reg  <= year5_reg;
            month_reg <= month5_reg;
            dom_reg   <= dom_full[4:0];
            hour_reg  <= hour5_reg;
            min_reg   <= min5_reg;
            sec_reg   <= sec5_reg;
        end
    end

    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = dom_reg;
    assign hour         = hour_reg;
    assign minute       = min_reg;
    assign second       = sec_reg;

endmodule
